// ----- hw/rtl/clre_pkg.sv -----
// clre_pkg: shared types and constants of the character LCD refresh engine
// no dependencies; imported by clre_front, clre_back and the top module

package clre_pkg;

  // default buffer geometry
  localparam int DEF_LINES   = 2;
  localparam int DEF_COLUMNS = 16;

  // input opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // display address arithmetic
  localparam int          ADDR_W        = 7;
  localparam logic [6:0]  LINE2_BASE    = 7'h40;
  localparam logic [6:0]  ADDR_MASK     = 7'h7f;
  localparam logic [7:0]  CMD_SET_DDRAM = 8'h80;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic       is_tick;
    logic       line;
    logic [3:0] column;
    logic [7:0] char_code;
  } cmd_t;

endpackage

// ----- hw/rtl/clre_ram.sv -----
// clre_ram: generic single write port, single read port ram, registered read
// depends on nothing

module clre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/clre_front.sv -----
// clre_front: input handshake, classification and two-entry command queue
// depends on clre_pkg

module clre_front import clre_pkg::*; #(
  parameter int LINES   = DEF_LINES,
  parameter int COLUMNS = DEF_COLUMNS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic       line,
  input  logic [3:0] column,
  input  logic [7:0] char_code,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  logic       cmd_ready
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t             q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             in_range;
  logic             keep;
  logic             push;
  logic             pop;
  cmd_t             entry;

  // writes outside the buffer are consumed and dropped here
  assign in_range = (int'(line) < LINES) && (int'(column) < COLUMNS);
  assign keep     = (op == OP_TICK) || in_range;

  assign entry.is_tick   = (op == OP_TICK);
  assign entry.line      = line;
  assign entry.column    = column;
  assign entry.char_code = char_code;

  assign in_ready  = (count != CNT_W'(QUEUE_DEPTH));
  assign push      = in_valid && in_ready && keep;
  assign cmd_valid = (count != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/clre_back.sv -----
// clre_back: executes queued commands; buffer writes, round-robin scan, nibble output
// depends on clre_pkg and clre_ram

module clre_back import clre_pkg::*; #(
  parameter int LINES   = DEF_LINES,
  parameter int COLUMNS = DEF_COLUMNS
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       is_data,
  output logic [3:0] nibble,
  output logic       last
);

  localparam int CELLS = LINES * COLUMNS;
  localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam logic [CW-1:0]    IDX_LAST  = CW'(CELLS - 1);
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);
  localparam logic             LINE_LAST = 1'(LINES - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } back_state_t;

  back_state_t       state;
  logic [CW-1:0]     scan_idx;
  logic              scan_line;
  logic [COL_W-1:0]  scan_column;
  logic [CW-1:0]     scan_cnt;
  logic [CELLS-1:0]  pending;
  logic [7:0]        addr_byte;
  logic [1:0]        nib_cnt;

  logic [CW-1:0]     adv_idx;
  logic              adv_line;
  logic [COL_W-1:0]  adv_column;
  logic              hit;
  logic [ADDR_W-1:0] addr_sum;
  logic [7:0]        addr_next;
  logic              cmd_pop;
  logic              do_write;
  logic [CW-1:0]     wr_idx;
  logic [7:0]        ch;

  // next cell in scan order after the current position
  always_comb begin
    if (scan_column == COL_LAST) begin
      adv_column = '0;
      adv_line   = (scan_line == LINE_LAST) ? 1'b0 : 1'b1;
    end else begin
      adv_column = scan_column + 1'b1;
      adv_line   = scan_line;
    end
    adv_idx = (scan_idx == IDX_LAST) ? '0 : scan_idx + 1'b1;
  end

  assign hit       = pending[adv_idx];
  assign addr_sum  = (adv_line ? LINE2_BASE : '0) + ADDR_W'(adv_column);
  assign addr_next = CMD_SET_DDRAM | {1'b0, addr_sum & ADDR_MASK};

  assign cmd_ready = (state == S_IDLE);
  assign cmd_pop   = cmd_valid && cmd_ready;
  assign do_write  = cmd_pop && !cmd.is_tick;
  assign wr_idx    = cmd.line ? (CW'(COLUMNS) + CW'(cmd.column)) : CW'(cmd.column);

  clre_ram #(
    .WIDTH(8),
    .DEPTH(CELLS)
  ) u_store (
    .clk  (clk),
    .we   (do_write),
    .waddr(wr_idx),
    .wdata(cmd.char_code),
    .re   ((state == S_SCAN) && hit),
    .raddr(adv_idx),
    .rdata(ch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      if (do_write) begin
        pending[wr_idx] <= (cmd.char_code != 8'd0);
      end
      if ((state == S_SCAN) && hit) begin
        pending[adv_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      scan_idx    <= '0;
      scan_line   <= 1'b0;
      scan_column <= '0;
      scan_cnt    <= '0;
      nib_cnt     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_pop && cmd.is_tick) begin
            scan_cnt <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // position always advances; a full miss lap ends where it began
          scan_idx    <= adv_idx;
          scan_line   <= adv_line;
          scan_column <= adv_column;
          if (hit) begin
            nib_cnt <= '0;
            state   <= S_EMIT;
          end else if (scan_cnt == IDX_LAST) begin
            state <= S_IDLE;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            nib_cnt <= nib_cnt + 1'b1;
            if (nib_cnt == 2'd3) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_SCAN) && hit) begin
      addr_byte <= addr_next;
    end
  end

  assign out_valid = (state == S_EMIT);
  assign is_data   = nib_cnt[1];
  assign last      = (nib_cnt == 2'd3);

  always_comb begin
    case (nib_cnt)
      2'd0:    nibble = addr_byte[7:4];
      2'd1:    nibble = addr_byte[3:0];
      2'd2:    nibble = ch[7:4];
      default: nibble = ch[3:0];
    endcase
  end

  a_served_cleared: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && hit) |=> !pending[$past(adv_idx)])
    else $error("served cell still pending");

  a_hit_starts_emit: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && hit) |=> (out_valid && (nib_cnt == 2'd0)))
    else $error("hit did not start a nibble sequence");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> (state == S_IDLE))
    else $error("back did not return to idle after last nibble");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(nib_cnt)))
    else $error("nibble sequence moved while stalled");

endmodule

// ----- hw/rtl/char_lcd_refresh_engine_top.sv -----
// char_lcd_refresh_engine_top: buffered refresh engine for a 4-bit character lcd bus
// depends on clre_pkg, clre_front, clre_back (and clre_ram below it)
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   in      | into blk  | in_valid / in_ready  | op, line, column, char_code
//   out     | out blk   | out_valid / out_ready| is_data, nibble, last
//
// a write transfer is stored in the buffer by the back end as it leaves the queue
// a refresh tick is dequeued, then the back end scans 1 to LINES*COLUMNS cells
//   (a one-bit-per-cycle walk over the pending flags) until one is pending; on a
//   hit it makes four out transfers, one per cycle when out_ready is high
// rst is synchronous: the buffer reads empty at once (pending flags cleared),
//   scan position returns to line 0 column 0
// the front queue holds two commands, so up to two inputs are still accepted
//   while the back end scans or waits on out_ready

module char_lcd_refresh_engine_top import clre_pkg::*; #(
  parameter int LINES   = DEF_LINES,
  parameter int COLUMNS = DEF_COLUMNS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic       line,
  input  logic [3:0] column,
  input  logic [7:0] char_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       is_data,
  output logic [3:0] nibble,
  output logic       last
);

  // queued command between front and back
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  // front: accepts transfers, drops writes outside the buffer, queues the rest
  clre_front #(
    .LINES  (LINES),
    .COLUMNS(COLUMNS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .line     (line),
    .column   (column),
    .char_code(char_code),
    .cmd      (cmd),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready)
  );

  // back: buffer writes, round-robin scan and nibble emission
  clre_back #(
    .LINES  (LINES),
    .COLUMNS(COLUMNS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .is_data  (is_data),
    .nibble   (nibble),
    .last     (last)
  );

endmodule
